@@ rtl/gha_pkg.sv @@
package gha_pkg;

    localparam int INDEX_BITS = 10;
    localparam int GEN_BITS   = 8;
    localparam int HANDLE_W   = 18;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = INDEX_BITS + 1;
    localparam int CFG_W      = 11;
    localparam int SLOT_COUNT = 1 << INDEX_BITS;

    localparam logic [ACTION_W-1:0] ACT_CREATE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DESTROY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NEVER    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic accept;
        logic gen_read;
        logic exec;
    } gha_cmd_t;

endpackage

@@ rtl/gha_ctrl.sv @@
module gha_ctrl
    import gha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output gha_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_QRD  = 2'd1;
    localparam logic [1:0] S_GRD  = 2'd2;
    localparam logic [1:0] S_EXEC = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.accept   = (state_reg == S_IDLE) && in_valid;
        cmd.gen_read = (state_reg == S_QRD);
        cmd.exec     = (state_reg == S_EXEC) && out_free;
        state_next   = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_QRD;
                end
            end
            S_QRD:
            begin
                state_next = S_GRD;
            end
            S_GRD:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/gha_dp.sv @@
module gha_dp
    import gha_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  gha_cmd_t            cmd,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic [ACTION_W-1:0] action,
    input  logic [HANDLE_W-1:0] handle_in,
    output logic [HANDLE_W-1:0] handle_out,
    output logic                alive,
    output logic [STATUS_W-1:0] status
);

    logic [GEN_BITS-1:0]   gen_mem [SLOT_COUNT];
    logic [INDEX_BITS-1:0] queue_mem [SLOT_COUNT];

    logic [CFG_W-1:0]      min_free_reg;
    logic [INDEX_BITS-1:0] head_reg;
    logic [INDEX_BITS-1:0] head_next;
    logic [INDEX_BITS-1:0] tail_reg;
    logic [INDEX_BITS-1:0] tail_next;
    logic [COUNT_W-1:0]    free_cnt_reg;
    logic [COUNT_W-1:0]    free_cnt_next;
    logic [COUNT_W-1:0]    alloc_cnt_reg;
    logic [COUNT_W-1:0]    alloc_cnt_next;

    logic [ACTION_W-1:0]   action_reg;
    logic [HANDLE_W-1:0]   handle_reg;
    logic [INDEX_BITS-1:0] q_rd_reg;
    logic [GEN_BITS-1:0]   gen_rd_reg;
    logic [HANDLE_W-1:0]   hout_reg;
    logic                  alive_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic [INDEX_BITS-1:0] idx;
    logic [GEN_BITS-1:0]   hgen;
    logic [CFG_W-1:0]      need;
    logic                  reuse;
    logic                  never;
    logic [INDEX_BITS-1:0] gen_raddr;
    logic                  gen_we;
    logic [INDEX_BITS-1:0] gen_waddr;
    logic [GEN_BITS-1:0]   gen_wdata;
    logic                  q_we;
    logic [HANDLE_W-1:0]   hout_next;
    logic                  alive_next;
    logic [STATUS_W-1:0]   status_next;

    assign idx   = handle_reg[INDEX_BITS-1:0];
    assign hgen  = handle_reg[INDEX_BITS +: GEN_BITS];
    assign need  = (min_free_reg == '0) ? CFG_W'(1) : min_free_reg;
    assign reuse = (CFG_W'(free_cnt_reg) >= need);
    assign never = ({1'b0, idx} >= alloc_cnt_reg);
    assign gen_raddr = ((action_reg == ACT_CREATE) && reuse) ? q_rd_reg : idx;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_cnt_next  = free_cnt_reg;
        alloc_cnt_next = alloc_cnt_reg;
        gen_we         = 1'b0;
        gen_waddr      = idx;
        gen_wdata      = gen_rd_reg + GEN_BITS'(1);
        q_we           = 1'b0;
        hout_next      = handle_reg;
        alive_next     = 1'b0;
        status_next    = ST_OK;
        case (action_reg)
            ACT_CREATE:
            begin
                if (reuse)
                begin
                    head_next     = head_reg + INDEX_BITS'(1);
                    free_cnt_next = free_cnt_reg - COUNT_W'(1);
                    hout_next     = HANDLE_W'({gen_rd_reg, q_rd_reg});
                end
                else if (alloc_cnt_reg < COUNT_W'(SLOT_COUNT))
                begin
                    gen_we         = 1'b1;
                    gen_waddr      = alloc_cnt_reg[INDEX_BITS-1:0];
                    gen_wdata      = '0;
                    alloc_cnt_next = alloc_cnt_reg + COUNT_W'(1);
                    hout_next      = HANDLE_W'(alloc_cnt_reg[INDEX_BITS-1:0]);
                end
                else
                begin
                    hout_next   = '0;
                    status_next = ST_FULL;
                end
            end
            ACT_DESTROY:
            begin
                if (never)
                begin
                    status_next = ST_NEVER;
                end
                else
                begin
                    gen_we = 1'b1;
                    if (free_cnt_reg >= COUNT_W'(SLOT_COUNT))
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        q_we          = 1'b1;
                        tail_next     = tail_reg + INDEX_BITS'(1);
                        free_cnt_next = free_cnt_reg + COUNT_W'(1);
                    end
                end
            end
            ACT_QUERY:
            begin
                if (never)
                begin
                    status_next = ST_NEVER;
                end
                else
                begin
                    alive_next = (gen_rd_reg == hgen);
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_free_reg  <= CFG_W'(1);
            head_reg      <= '0;
            tail_reg      <= '0;
            free_cnt_reg  <= '0;
            alloc_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_free_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                free_cnt_reg  <= free_cnt_next;
                alloc_cnt_reg <= alloc_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            action_reg <= action;
            handle_reg <= handle_in;
            q_rd_reg   <= queue_mem[head_reg];
        end
        if (cmd.exec && q_we)
        begin
            queue_mem[tail_reg] <= idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.gen_read)
        begin
            gen_rd_reg <= gen_mem[gen_raddr];
        end
        if (cmd.exec && gen_we)
        begin
            gen_mem[gen_waddr] <= gen_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            hout_reg   <= hout_next;
            alive_reg  <= alive_next;
            status_reg <= status_next;
        end
    end

    assign handle_out = hout_reg;
    assign alive      = alive_reg;
    assign status     = status_reg;

endmodule

@@ rtl/generational_handle_allocator_top.sv @@
// Generational handle allocator.
// Input channel (in_valid / in_stall) carries one transaction: action
// (create, destroy, alive query) and handle_in. Output channel
// (out_valid / out_stall) returns handle_out, alive and status for each one.
// One transaction is worked at a time: accept it while reading the free queue
// head, read the generation memory (its address may come from the queue),
// pass a wait step, then update both memories and load the output register.
// A new transaction is taken only after the last one has passed the acceptance,
// generation read, wait and update steps.
// The output register lets the next transaction start while a result waits.
// If the receiver stalls with a result still held, the block finishes its
// reads and holds in the update step until the output register frees.
// Reset clears the queue pointers and counters and sets min_free to 1; memory
// contents are not cleared, so no clearing pass is needed. min_free is written
// via cfg_we / cfg_wdata by the user, only when idle; the block does not check.
module generational_handle_allocator_top
    import gha_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic [HANDLE_W-1:0] handle_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [HANDLE_W-1:0] handle_out,
    output logic                alive,
    output logic [STATUS_W-1:0] status
);

    gha_cmd_t cmd;

    gha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    gha_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .action     (action),
        .handle_in  (handle_in),
        .handle_out (handle_out),
        .alive      (alive),
        .status     (status)
    );

endmodule
